### hw/rtl/s2d_pkg.sv
// Shared types, constants and helpers for the signed integer to decimal text unit.
`default_nettype none

package s2d_pkg;

  localparam int VALUE_W = 32;
  localparam int MAG_W = 32;
  localparam int CHAR_W = 6;
  localparam int THR_W = 34;
  localparam int NDIG = 10;
  localparam int POS_W = 4;
  localparam int DIG_W = 4;
  localparam int DEF_QUEUE_DEPTH = 2;

  localparam logic [CHAR_W-1:0] ZERO_CHAR = 6'd48;
  localparam logic [CHAR_W-1:0] NINE_CHAR = 6'd57;
  localparam logic [CHAR_W-1:0] MINUS_CHAR = 6'd45;

  localparam logic [THR_W-1:0] POW10 [NDIG] = '{
    34'd1, 34'd10, 34'd100, 34'd1000, 34'd10000, 34'd100000,
    34'd1000000, 34'd10000000, 34'd100000000, 34'd1000000000
  };

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [POS_W-1:0] ndig;
  } item_t;

  function automatic logic [THR_W-1:0] thresh(input logic [POS_W-1:0] pos,
                                               input logic [DIG_W-1:0] d);
    logic [THR_W-1:0] p;
    p = POW10[pos];
    return p * THR_W'(d);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/s2d_front.sv
// Front end: accepts a word, forms sign, magnitude and digit count.
`default_nettype none

module s2d_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [s2d_pkg::VALUE_W-1:0] value,
  input  logic                          full,
  output logic                          busy,
  output logic                          push,
  output s2d_pkg::item_t                item
);
  import s2d_pkg::*;

  logic               held;
  logic [VALUE_W-1:0] raw;
  logic [MAG_W-1:0]   mag;
  logic [NDIG-2:0]    above;

  always_comb begin
    mag = raw[VALUE_W-1] ? (MAG_W'(0) - raw) : raw;
    for (int k = 1; k < NDIG; k++) begin
      above[k-1] = {2'b00, mag} >= POW10[k];
    end
    item.neg  = raw[VALUE_W-1];
    item.mag  = mag;
    item.ndig = POS_W'(1) + POS_W'($countones(above));
  end

  assign busy = held && full;
  assign push = held && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (start && !busy) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      raw <= value;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/s2d_queue.sv
// Short queue of classified words between front and back.
`default_nettype none

module s2d_queue #(
  parameter int DEPTH = s2d_pkg::DEF_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  s2d_pkg::item_t wr_item,
  input  logic           pop,
  output s2d_pkg::item_t rd_item,
  output logic           full,
  output logic           empty
);
  import s2d_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = count == CNT_W'(DEPTH);
  assign empty   = count == CNT_W'(0);
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/s2d_back.sv
// Back end: emits the minus sign and digits of one word, most significant first.
`default_nettype none

module s2d_back (
  input  logic                        clk,
  input  logic                        rst,
  input  s2d_pkg::item_t              head,
  input  logic                        empty,
  output logic                        pop,
  output logic                        strobe,
  output logic [s2d_pkg::CHAR_W-1:0]  character,
  output logic                        last
);
  import s2d_pkg::*;

  typedef enum logic [1:0] {IDLE, SIGN, DIGIT} state_t;

  state_t           state;
  logic [MAG_W-1:0] mag;
  logic [POS_W-1:0] pos;
  logic [THR_W-1:0] thr [NDIG-1];
  logic [NDIG-2:0]  ge;
  logic [DIG_W-1:0] digit;
  logic [THR_W-1:0] sub;

  always_comb begin
    sub = '0;
    for (int d = 1; d < NDIG; d++) begin
      thr[d-1] = thresh(pos, DIG_W'(d));
      ge[d-1]  = {2'b00, mag} >= thr[d-1];
      if (ge[d-1]) begin
        sub = thr[d-1];
      end
    end
    digit = DIG_W'($countones(ge));
  end

  assign pop = !empty && ((state == IDLE) || ((state == DIGIT) && (pos == '0)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      strobe <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          strobe <= 1'b0;
          if (pop) begin
            mag   <= head.mag;
            pos   <= head.ndig - POS_W'(1);
            state <= head.neg ? SIGN : DIGIT;
          end
        end
        SIGN: begin
          strobe    <= 1'b1;
          character <= MINUS_CHAR;
          last      <= 1'b0;
          state     <= DIGIT;
        end
        DIGIT: begin
          strobe    <= 1'b1;
          character <= ZERO_CHAR + CHAR_W'(digit);
          last      <= pos == '0;
          if (pos == '0) begin
            if (pop) begin
              mag   <= head.mag;
              pos   <= head.ndig - POS_W'(1);
              state <= head.neg ? SIGN : DIGIT;
            end else begin
              state <= IDLE;
            end
          end else begin
            mag <= mag - MAG_W'(sub);
            pos <= pos - POS_W'(1);
          end
        end
        default: begin
          strobe <= 1'b0;
          state  <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (character == MINUS_CHAR) ||
               ((character >= ZERO_CHAR) && (character <= NINE_CHAR)))
    else $error("character outside minus and digit codes");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && (character == MINUS_CHAR)) |-> !last)
    else $error("minus sign marked last");

  a_minus_then_digit: assert property (@(posedge clk) disable iff (rst)
    (strobe && (character == MINUS_CHAR)) |=> (strobe && (character != MINUS_CHAR)))
    else $error("minus sign not followed by a digit");
`endif

endmodule

`default_nettype wire

### hw/rtl/signed_int_to_decimal_ascii_unit.sv
// Top level of the signed 32-bit integer to decimal ASCII text unit.
// Usage:
//   Drive value and raise start; the word is taken at a rising edge where
//   start is high and busy is low. busy rises only while the front register
//   holds a word and the queue behind it is full.
//   Each output character shows on character with strobe high for exactly one
//   cycle; last marks the final character of a number. A negative number
//   starts with '-', leading zeros are dropped, zero gives a single '0'.
// Path: an accepted word moves from the front register into the queue; the back
//   end pops it when idle or on its last digit and registers each character.
// Throughput: one character per cycle, 1 to 11 characters per word, set by the
//   back end's one-digit-per-cycle compare against the powers of ten; words
//   waiting in the queue follow with no gap.
// Reset: rst (synchronous) empties the front register and the queue and
//   returns the back end to idle; no strobe is issued during reset.
// The receiver cannot stall: every strobed character must be taken.
`default_nettype none

module signed_int_to_decimal_ascii_unit #(
  parameter int QUEUE_DEPTH = s2d_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [s2d_pkg::VALUE_W-1:0] value,
  output logic                               strobe,
  output logic [s2d_pkg::CHAR_W-1:0]         character,
  output logic                               last
);
  import s2d_pkg::*;

  item_t front_item;
  item_t head_item;
  logic  push;
  logic  pop;
  logic  full;
  logic  empty;

  s2d_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .value (value),
    .full  (full),
    .busy  (busy),
    .push  (push),
    .item  (front_item)
  );

  s2d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (front_item),
    .pop     (pop),
    .rd_item (head_item),
    .full    (full),
    .empty   (empty)
  );

  s2d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head_item),
    .empty     (empty),
    .pop       (pop),
    .strobe    (strobe),
    .character (character),
    .last      (last)
  );

endmodule

`default_nettype wire
